// ----- rtl/bmc_pkg.sv -----
// shared constants for the bitwise majority centroid unit
package bmc_pkg;

  localparam int CLUSTERS_DEF         = 64;
  localparam int DESCRIPTOR_BYTES_DEF = 32;
  localparam int COUNT_BITS_DEF       = 16;

  // at most this many centroid bytes leave per emit
  localparam int MAX_OUT = 32;

  localparam int BYTE_W    = 8;
  localparam int CLUSTER_W = 6;
  localparam int POS_W     = 5;
  localparam int MEMBERS_W = 16;

  localparam logic CMD_ACCUMULATE = 1'b0;
  localparam logic CMD_EMIT       = 1'b1;

endpackage

// ----- rtl/bitwise_majority_centroid_unit.sv -----
// top level of the bitwise majority centroid unit
//
// Builds binary cluster centers by per-bit majority vote. An accumulate
// transaction (in_command = accumulate) adds the eight bits of one descriptor
// byte to the saturating counters of its cluster and byte position, and adds
// one member when in_closes_descriptor is set. An emit transaction streams
// the cluster's centroid, one byte per cycle on out_valid, positions 0 up to
// min(DESCRIPTOR_BYTES, 32) - 1, with out_last on the final byte, then leaves
// the cluster's counters cleared. The receiver cannot stall: each result is
// on the out_ ports for exactly one cycle. A transaction is taken when start
// is high and busy is low. An accumulate keeps busy high in the cycle after
// it is taken, while it writes back the row it read, an emit keeps busy high
// while it reads out and clears each byte position of its cluster, and an
// item naming a cluster at or above CLUSTERS is dropped without raising busy.
// The counter memory has a registered read port beside a separate write
// port. Results of an emit leave in the cycle after the memory read data.
// After reset the block sweeps the counter memory clear, one row per cycle,
// and holds busy high until the sweep is done.
module bitwise_majority_centroid_unit
  import bmc_pkg::*;
#(
  parameter int CLUSTERS         = CLUSTERS_DEF,
  parameter int DESCRIPTOR_BYTES = DESCRIPTOR_BYTES_DEF,
  parameter int COUNT_BITS       = COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_command,
  input  logic [CLUSTER_W-1:0] in_cluster,
  input  logic [POS_W-1:0]     in_byte_position,
  input  logic [BYTE_W-1:0]    in_data_byte,
  input  logic                 in_closes_descriptor,
  output logic                 out_valid,
  output logic [CLUSTER_W-1:0] out_cluster,
  output logic [POS_W-1:0]     out_position,
  output logic [BYTE_W-1:0]    out_centroid_byte,
  output logic [MEMBERS_W-1:0] out_members,
  output logic                 out_last
);

  localparam int CL_W  = $clog2(CLUSTERS);
  localparam int ROWS  = CLUSTERS * DESCRIPTOR_BYTES;
  localparam int RA_W  = $clog2(ROWS);
  localparam int PC_W  = $clog2(DESCRIPTOR_BYTES + 1);
  localparam int N_OUT = (DESCRIPTOR_BYTES < MAX_OUT) ? DESCRIPTOR_BYTES : MAX_OUT;

  // one row holds the eight bit counters of one cluster and byte position
  typedef logic [COUNT_BITS-1:0]             count_t;
  typedef logic [BYTE_W-1:0][COUNT_BITS-1:0] row_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLEAR,
    S_ACC,
    S_EMIT
  } state_t;

  localparam count_t COUNT_MAX = '1;

  // control registers
  state_t state_r, state_nxt;
  logic [RA_W-1:0] clr_r;
  logic [PC_W-1:0] q_r;

  // transaction captured at accept
  logic [CLUSTER_W-1:0] cl_r;
  logic [CL_W-1:0]      cl_idx_r;
  logic [RA_W-1:0]      base_r;
  logic [RA_W-1:0]      addr_r;
  logic [BYTE_W-1:0]    data_r;
  logic                 pos_ok_r;
  logic                 closes_r;

  // result registers
  logic                 out_valid_r;
  logic [CLUSTER_W-1:0] out_cluster_r;
  logic [POS_W-1:0]     out_position_r;
  logic [BYTE_W-1:0]    out_byte_r;
  logic [MEMBERS_W-1:0] out_members_r;
  logic                 out_last_r;

  // memories and their ports
  row_t   row_mem [ROWS];
  count_t mbr_mem [CLUSTERS];
  row_t   row_rd_r;
  count_t mbr_rd_r;

  logic            row_re, row_we;
  logic [RA_W-1:0] row_raddr, row_waddr;
  row_t            row_wdata;
  logic            mbr_re, mbr_we;
  logic [CL_W-1:0] mbr_raddr, mbr_waddr;
  count_t          mbr_wdata;

  // decode of the incoming transaction
  logic            accept;
  logic            in_range;
  logic            pos_ok;
  logic [CL_W-1:0] cl_idx;
  logic [RA_W-1:0] base;
  logic [RA_W-1:0] acc_addr;
  logic            q_last;
  row_t            row_inc;
  logic [BYTE_W-1:0]    vote_byte;
  logic [MEMBERS_W-1:0] members_sat;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign in_range = 32'(in_cluster) < 32'(CLUSTERS);
  assign pos_ok   = 32'(in_byte_position) < 32'(DESCRIPTOR_BYTES);
  assign cl_idx   = CL_W'(in_cluster);
  assign base     = RA_W'(RA_W'(cl_idx) * RA_W'(DESCRIPTOR_BYTES));
  assign acc_addr = base + RA_W'(in_byte_position);
  assign q_last   = (q_r == PC_W'(DESCRIPTOR_BYTES - 1));

  // saturating add of each set bit to its counter
  always_comb begin
    for (int b = 0; b < BYTE_W; b++) begin
      if (data_r[b] && (row_rd_r[b] != COUNT_MAX)) begin
        row_inc[b] = row_rd_r[b] + count_t'(1);
      end else begin
        row_inc[b] = row_rd_r[b];
      end
    end
  end

  bmc_vote #(
    .COUNT_BITS(COUNT_BITS)
  ) u_vote (
    .counts      (row_rd_r),
    .member_count(mbr_rd_r),
    .vote_byte   (vote_byte),
    .members_sat (members_sat)
  );

  // memory port control and next state
  always_comb begin
    state_nxt = state_r;
    row_re    = 1'b0;
    row_raddr = acc_addr;
    row_we    = 1'b0;
    row_waddr = addr_r;
    row_wdata = '0;
    mbr_re    = 1'b0;
    mbr_raddr = cl_idx;
    mbr_we    = 1'b0;
    mbr_waddr = cl_idx_r;
    mbr_wdata = '0;
    case (state_r)
      S_CLEAR: begin
        row_we    = 1'b1;
        row_waddr = clr_r;
        mbr_we    = 32'(clr_r) < 32'(CLUSTERS);
        mbr_waddr = CL_W'(clr_r);
        if (clr_r == RA_W'(ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        // out of range clusters are taken and dropped
        if (accept && in_range) begin
          mbr_re = 1'b1;
          if (in_command == CMD_EMIT) begin
            row_re    = 1'b1;
            row_raddr = base;
            state_nxt = S_EMIT;
          end else begin
            row_re    = pos_ok;
            state_nxt = S_ACC;
          end
        end
      end
      S_ACC: begin
        row_we    = pos_ok_r;
        row_wdata = row_inc;
        mbr_we    = closes_r;
        mbr_wdata = (mbr_rd_r == COUNT_MAX) ? mbr_rd_r : mbr_rd_r + count_t'(1);
        state_nxt = S_IDLE;
      end
      S_EMIT: begin
        // clear the row just read, fetch the next one
        row_we    = 1'b1;
        row_waddr = base_r + RA_W'(q_r);
        row_raddr = base_r + RA_W'(q_r) + RA_W'(1);
        row_re    = !q_last;
        if (q_last) begin
          mbr_we    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // counter rows
  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    if (row_re) begin
      row_rd_r <= row_mem[row_raddr];
    end
  end

  // member counts
  always_ff @(posedge clk) begin
    if (mbr_we) begin
      mbr_mem[mbr_waddr] <= mbr_wdata;
    end
    if (mbr_re) begin
      mbr_rd_r <= mbr_mem[mbr_raddr];
    end
  end

  // state, counters and registered results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      q_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_EMIT) && (32'(q_r) < 32'(N_OUT));
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + RA_W'(1);
      end
      if (state_r == S_EMIT) begin
        q_r <= q_r + PC_W'(1);
      end else begin
        q_r <= '0;
      end
    end
    if (accept) begin
      cl_r     <= in_cluster;
      cl_idx_r <= cl_idx;
      base_r   <= base;
      addr_r   <= acc_addr;
      data_r   <= in_data_byte;
      pos_ok_r <= pos_ok;
      closes_r <= in_closes_descriptor;
    end
    out_cluster_r  <= cl_r;
    out_position_r <= POS_W'(q_r);
    out_byte_r     <= vote_byte;
    out_members_r  <= members_sat;
    out_last_r     <= (q_r == PC_W'(N_OUT - 1));
  end

  assign out_valid         = out_valid_r;
  assign out_cluster       = out_cluster_r;
  assign out_position      = out_position_r;
  assign out_centroid_byte = out_byte_r;
  assign out_members       = out_members_r;
  assign out_last          = out_last_r && out_valid_r;

endmodule

// ----- rtl/bmc_vote.sv -----
// per-bit majority vote of one counter row and member count saturation
module bmc_vote
  import bmc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic [BYTE_W-1:0][COUNT_BITS-1:0] counts,
  input  logic [COUNT_BITS-1:0]             member_count,
  output logic [BYTE_W-1:0]                 vote_byte,
  output logic [MEMBERS_W-1:0]              members_sat
);

  // bit set when twice its count exceeds the members, ties give zero
  always_comb begin
    for (int b = 0; b < BYTE_W; b++) begin
      vote_byte[b] = {counts[b], 1'b0} > {1'b0, member_count};
    end
  end

  always_comb begin
    if (32'(member_count) > 32'((1 << MEMBERS_W) - 1)) begin
      members_sat = '1;
    end else begin
      members_sat = MEMBERS_W'(member_count);
    end
  end

endmodule

// ----- rtl/bmc_checker.sv -----
// port-level checks for the bitwise majority centroid unit and their binding
module bmc_checker
  import bmc_pkg::*;
#(
  parameter int CLUSTERS = CLUSTERS_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic [CLUSTER_W-1:0] in_cluster,
  input logic                 out_valid,
  input logic [POS_W-1:0]     out_position,
  input logic                 out_last
);

  // a centroid streams without gaps up to its last byte
  a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("centroid burst broken before last byte");

  // byte positions count up within a burst
  a_position_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_position == $past(out_position) + 5'd1)
    else $error("centroid byte position did not advance");

  // the unit stays busy while more bytes of a centroid are due
  a_busy_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("unit idle in the middle of a centroid");

  // a burst opens with position zero
  a_burst_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_position == '0)
    else $error("centroid burst did not start at position zero");

  // an in-range transaction always occupies the following cycle
  a_taken_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (32'(in_cluster) < 32'(CLUSTERS)) |=> busy)
    else $error("transaction taken without a working cycle");

endmodule

bind bitwise_majority_centroid_unit bmc_checker #(
  .CLUSTERS(CLUSTERS)
) u_bmc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_cluster  (in_cluster),
  .out_valid   (out_valid),
  .out_position(out_position),
  .out_last    (out_last)
);

// ----- tb/tb_bitwise_majority_centroid_unit.sv -----
// self-checking testbench for the bitwise majority centroid unit
module tb_bitwise_majority_centroid_unit;
  import bmc_pkg::*;

  // block configuration as built, taken from the package defaults
  localparam int N_CLUSTERS  = CLUSTERS_DEF;
  localparam int N_BYTES     = DESCRIPTOR_BYTES_DEF;
  localparam int N_OUT_BYTES = (N_BYTES < MAX_OUT) ? N_BYTES : MAX_OUT;
  localparam logic [COUNT_BITS_DEF-1:0] COUNT_MAX = '1;

  // settle time after the last expected byte, covers an emit's full read-out
  localparam int DRAIN_CYCLES = N_BYTES + 16;
  // cycle bound above the slowest correct run (clear sweep plus every item an
  // emit with the longest sender gaps and a full drain after each)
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int MAX_REPORT_LINES = 40;

  // one centroid byte as it leaves the block
  typedef struct packed {
    logic [CLUSTER_W-1:0] cluster;
    logic [POS_W-1:0]     position;
    logic [BYTE_W-1:0]    centroid;
    logic [MEMBERS_W-1:0] members;
    logic                 last;
  } centroid_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_command = CMD_ACCUMULATE;
  logic [CLUSTER_W-1:0] in_cluster = '0;
  logic [POS_W-1:0] in_byte_position = '0;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic in_closes_descriptor = 1'b0;
  logic out_valid;
  logic [CLUSTER_W-1:0] out_cluster;
  logic [POS_W-1:0] out_position;
  logic [BYTE_W-1:0] out_centroid_byte;
  logic [MEMBERS_W-1:0] out_members;
  logic out_last;

  // predictor state: per-bit vote counters and member counters
  logic [COUNT_BITS_DEF-1:0] bit_tally [N_CLUSTERS][N_BYTES][BYTE_W];
  logic [COUNT_BITS_DEF-1:0] member_tally [N_CLUSTERS];

  // centroid bytes predicted but not yet seen on the out_ ports
  centroid_byte_t expected_centroid_bytes [$];

  int error_count = 0;
  int items_sent = 0;
  int idle_chance = 0;  // percent chance of a sender gap before a transaction
  int unsigned cycle_count = 0;

  bitwise_majority_centroid_unit i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_command           (in_command),
    .in_cluster           (in_cluster),
    .in_byte_position     (in_byte_position),
    .in_data_byte         (in_data_byte),
    .in_closes_descriptor (in_closes_descriptor),
    .out_valid            (out_valid),
    .out_cluster          (out_cluster),
    .out_position         (out_position),
    .out_centroid_byte    (out_centroid_byte),
    .out_members          (out_members),
    .out_last             (out_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog: a hung handshake or a missing result ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still expected", cycle_count,
               expected_centroid_bytes.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORT_LINES) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want, input centroid_byte_t ctx);
    if (got !== want)
      report_mismatch($sformatf("cluster %0d position %0d %s: got %0h expected %0h",
                                ctx.cluster, ctx.position, name, got, want));
  endtask

  // accumulate transaction: one saturating vote per set bit, one member on close
  task automatic tally_byte(input logic [CLUSTER_W-1:0] cl, input logic [POS_W-1:0] pos,
                            input logic [BYTE_W-1:0] data, input logic closes);
    if (cl < N_CLUSTERS) begin
      if (pos < N_BYTES) begin
        for (int b = 0; b < BYTE_W; b++)
          if (data[b] && bit_tally[cl][pos][b] != COUNT_MAX)
            bit_tally[cl][pos][b] = bit_tally[cl][pos][b] + 1'b1;
      end
      if (closes && member_tally[cl] != COUNT_MAX)
        member_tally[cl] = member_tally[cl] + 1'b1;
    end
  endtask

  // emit transaction: majority vote per bit (ties give zero), then clear the cluster
  task automatic predict_centroid(input logic [CLUSTER_W-1:0] cl);
    centroid_byte_t cb;
    if (cl < N_CLUSTERS) begin
      for (int p = 0; p < N_OUT_BYTES; p++) begin
        cb.cluster  = cl;
        cb.position = POS_W'(p);
        cb.members  = MEMBERS_W'(member_tally[cl]);
        cb.last     = (p == N_OUT_BYTES - 1);
        for (int b = 0; b < BYTE_W; b++)
          cb.centroid[b] = (2 * int'(bit_tally[cl][p][b])) > int'(member_tally[cl]);
        expected_centroid_bytes.push_back(cb);
      end
      for (int p = 0; p < N_BYTES; p++)
        for (int b = 0; b < BYTE_W; b++)
          bit_tally[cl][p][b] = '0;
      member_tally[cl] = '0;
    end
  endtask

  // drive one transaction and hold it until the block takes it;
  // returns at the accepting edge with start still high
  task automatic send_item(input logic cmd, input logic [CLUSTER_W-1:0] cl,
                           input logic [POS_W-1:0] pos, input logic [BYTE_W-1:0] data,
                           input logic closes);
    if (idle_chance != 0 && $urandom_range(0, 99) < idle_chance) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start                <= 1'b1;
    in_command           <= cmd;
    in_cluster           <= cl;
    in_byte_position     <= pos;
    in_data_byte         <= data;
    in_closes_descriptor <= closes;
    do @(posedge clk); while (busy !== 1'b0);
    items_sent++;
    if (cmd == CMD_EMIT) predict_centroid(cl);
    else tally_byte(cl, pos, data, closes);
  endtask

  task automatic send_byte(input logic [CLUSTER_W-1:0] cl, input logic [POS_W-1:0] pos,
                           input logic [BYTE_W-1:0] data, input logic closes);
    send_item(CMD_ACCUMULATE, cl, pos, data, closes);
  endtask

  // the unused fields of an emit carry noise, the block must ignore them
  task automatic send_emit(input logic [CLUSTER_W-1:0] cl);
    send_item(CMD_EMIT, cl, POS_W'($urandom), BYTE_W'($urandom), 1'($urandom));
  endtask

  // sender holds off until every predicted byte has come out
  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (expected_centroid_bytes.size() != 0);
  endtask

  // results are registered and stable for the whole cycle, so they are read
  // mid-cycle, clear of the edge where the predictor queues new ones
  always @(negedge clk) begin
    centroid_byte_t want;
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      if (expected_centroid_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected centroid byte: cluster %0d position %0d",
                                  out_cluster, out_position));
      end else begin
        want = expected_centroid_bytes.pop_front();
        check_field("out_valid", 32'(out_valid), 32'd1, want);
        check_field("cluster", 32'(out_cluster), 32'(want.cluster), want);
        check_field("position", 32'(out_position), 32'(want.position), want);
        check_field("centroid byte", 32'(out_centroid_byte), 32'(want.centroid), want);
        check_field("members", 32'(out_members), 32'(want.members), want);
        check_field("last", 32'(out_last), 32'(want.last), want);
      end
    end
  end

  // empty clusters: zero members, so any nonzero vote count reads as one
  task automatic test_empty_clusters();
    idle_chance = 0;
    send_emit(6'd0);                       // untouched since the clear sweep
    send_byte(6'd10, 5'd3, 8'hA5, 1'b0);   // votes but no member
    send_emit(6'd10);
    send_byte(6'd1, 5'd0, 8'h00, 1'b1);    // member with no votes
    send_emit(6'd1);
    wait_for_results();
  endtask

  // highest cluster and position, all-ones and top-bit bytes, emits back to back
  task automatic test_extreme_fields();
    idle_chance = 0;
    send_byte(6'd63, 5'd31, 8'hFF, 1'b0);
    send_byte(6'd63, 5'd0, 8'h80, 1'b1);
    send_byte(6'd62, 5'd31, 8'h01, 1'b1);
    send_emit(6'd63);
    send_emit(6'd63);                      // must read back all zero after the clear
    send_emit(6'd62);
  endtask

  // two members: a bit needs both votes, one vote is a tie and gives zero
  task automatic test_majority_ties();
    idle_chance = 25;
    send_byte(6'd5, 5'd0, 8'hF0, 1'b1);
    send_byte(6'd5, 5'd0, 8'h3C, 1'b1);
    send_byte(6'd5, 5'd31, 8'h01, 1'b0);
    send_byte(6'd5, 5'd16, 8'h7E, 1'b0);
    send_byte(6'd5, 5'd16, 8'h7E, 1'b0);
    send_byte(6'd5, 5'd16, 8'h42, 1'b1);   // three members, two or more votes win
    send_emit(6'd5);
    wait_for_results();
  endtask

  // mostly well-formed descriptor groups around a per-group bit pattern,
  // plus stray bytes and emits of arbitrary clusters
  task automatic test_random_traffic(input int n_items, input bit allow_idle);
    int target;
    int scenario;
    int n_desc;
    int len;
    logic [CLUSTER_W-1:0] cl;
    logic [BYTE_W-1:0] pattern;
    logic [BYTE_W-1:0] data;
    target = items_sent + n_items;
    while (items_sent < target) begin
      // alternate stretches with and without sender gaps
      idle_chance = (allow_idle && $urandom_range(0, 1)) ? 35 : 0;
      scenario = $urandom_range(0, 9);
      if (scenario <= 6) begin
        cl = CLUSTER_W'($urandom_range(0, N_CLUSTERS - 1));
        pattern = BYTE_W'($urandom);
        n_desc = $urandom_range(1, 5);
        for (int d = 0; d < n_desc; d++) begin
          len = ($urandom_range(0, 7) == 0) ? N_BYTES : $urandom_range(1, 6);
          for (int p = 0; p < len; p++) begin
            data = ($urandom_range(0, 2) == 0) ? pattern ^ BYTE_W'($urandom) : pattern;
            send_byte(cl, POS_W'(p), data, p == len - 1);
          end
        end
        if ($urandom_range(0, 9) != 0) send_emit(cl);
      end else if (scenario <= 8) begin
        send_byte(CLUSTER_W'($urandom), POS_W'($urandom), BYTE_W'($urandom),
                  1'($urandom));
      end else begin
        send_emit(CLUSTER_W'($urandom_range(0, N_CLUSTERS - 1)));
      end
      if ($urandom_range(0, 9) == 0) wait_for_results();
    end
  endtask

  initial begin
    for (int c = 0; c < N_CLUSTERS; c++) begin
      member_tally[c] = '0;
      for (int p = 0; p < N_BYTES; p++)
        for (int b = 0; b < BYTE_W; b++)
          bit_tally[c][p][b] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_clusters();
    test_extreme_fields();
    test_majority_ties();
    test_random_traffic(300, 1'b1);
    test_random_traffic(150, 1'b0);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
